@@ sv/frame_rate_classifier_defines.svh @@
// Assertion helpers used by the verification file frc_checker.sv.
`ifndef FRAME_RATE_CLASSIFIER_DEFINES_SVH
`define FRAME_RATE_CLASSIFIER_DEFINES_SVH

// Checked at every clock edge, reset included.
`define FRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define FRC_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`endif

@@ sv/frc_pkg.sv @@
package frc_pkg;

  localparam int TS_W      = 64;
  localparam int IV_W      = 30;
  localparam int CNT_W     = 7;
  localparam int RUN_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CNT_W-1:0] SAMPLE_CAP = 7'd120;
  localparam logic [RUN_W-1:0] RUN_MAX    = 8'd255;

  // rate_class codes as seen on the output
  localparam logic [1:0] RC_UNDECIDED = 2'd0;
  localparam logic [1:0] RC_LOW       = 2'd1;
  localparam logic [1:0] RC_HIGH      = 2'd2;

  typedef enum logic [1:0] {
    ACT_NORMAL      = 2'd0,
    ACT_PASSTHROUGH = 2'd1,
    ACT_MEASURING   = 2'd2,
    ACT_GENERATE    = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    RS_UNDECIDED = 3'b001,
    RS_LOW       = 3'b010,
    RS_HIGH      = 3'b100
  } rs_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_INTERVAL   = 3'd0,
    CFG_MAX_INTERVAL   = 3'd1,
    CFG_HIGH_RATE_LIM  = 3'd2,
    CFG_SLOW_INTERVAL  = 3'd3,
    CFG_MIN_SAMPLES    = 3'd4,
    CFG_SLOW_RUN_LIMIT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [IV_W-1:0]  min_interval_ns;
    logic [IV_W-1:0]  max_interval_ns;
    logic [IV_W-1:0]  high_rate_limit_ns;
    logic [IV_W-1:0]  slow_interval_ns;
    logic [CNT_W-1:0] min_samples;
    logic [RUN_W-1:0] slow_run_limit;
  } cfg_t;

  // observe stage -> classify stage
  typedef struct packed {
    logic [IV_W-1:0]  interval;
    logic [CNT_W-1:0] count;
  } obs_t;

  // classify stage -> state registers
  typedef struct packed {
    rs_t              rate_state;
    logic [RUN_W-1:0] slow_run;
    logic             previous_enabled;
    logic             clear;
    action_t          action;
  } cls_t;

  function automatic logic [1:0] rate_code(rs_t rs);
    logic [1:0] code;
    case (rs)
      RS_LOW:  code = RC_LOW;
      RS_HIGH: code = RC_HIGH;
      default: code = RC_UNDECIDED;
    endcase
    return code;
  endfunction

endpackage

@@ sv/frc_observe.sv @@
module frc_observe import frc_pkg::*; #(
  parameter int AVG_FRAC_BITS = 8
) (
  input  logic [TS_W-1:0]               now,
  input  logic                          observe_en,
  input  logic [TS_W-1:0]               last_stamp,
  input  logic [IV_W+AVG_FRAC_BITS-1:0] average,
  input  logic [CNT_W-1:0]              count,
  input  cfg_t                          cfg,
  output logic [TS_W-1:0]               last_stamp_next,
  output logic [IV_W+AVG_FRAC_BITS-1:0] average_next,
  output obs_t                          obs
);

  localparam int AVG_W = IV_W + AVG_FRAC_BITS;

  logic [TS_W-1:0]  diff;
  logic             stamp_ok;
  logic             in_window;
  logic             take;
  logic [AVG_W-1:0] sample_fixed;
  logic [AVG_W+2:0] blend_sum;

  assign diff      = now - last_stamp;
  assign stamp_ok  = (last_stamp != '0) && (now > last_stamp);
  // anything with bits above the low 30 is past any max interval
  assign in_window = (diff[TS_W-1:IV_W] == '0) &&
                     (diff[IV_W-1:0] >= cfg.min_interval_ns) &&
                     (diff[IV_W-1:0] <= cfg.max_interval_ns);
  assign take      = observe_en && stamp_ok && in_window;

  assign sample_fixed = AVG_W'(diff[IV_W-1:0]) << AVG_FRAC_BITS;
  // 7/8 old + 1/8 new, truncated
  assign blend_sum = ((AVG_W+3)'(average) << 3) - (AVG_W+3)'(average)
                     + (AVG_W+3)'(sample_fixed);

  always_comb begin
    average_next = average;
    obs.count    = count;
    obs.interval = '0;
    if (take) begin
      average_next = (count == '0) ? sample_fixed : blend_sum[AVG_W+2:3];
      obs.interval = diff[IV_W-1:0];
      if (count < SAMPLE_CAP) begin
        obs.count = count + 1'b1;
      end
    end
  end

  assign last_stamp_next = observe_en ? now : last_stamp;

endmodule

@@ sv/frc_classify.sv @@
module frc_classify import frc_pkg::*; #(
  parameter int AVG_FRAC_BITS = 8
) (
  input  logic                          enabled,
  input  logic                          compatible,
  input  logic                          previous_enabled,
  input  rs_t                           rate_state,
  input  logic [RUN_W-1:0]              slow_run,
  input  obs_t                          obs,
  input  logic [IV_W+AVG_FRAC_BITS-1:0] average,
  input  cfg_t                          cfg,
  output cls_t                          cls
);

  localparam int AVG_W = IV_W + AVG_FRAC_BITS;

  logic [AVG_W-1:0] limit_fixed;
  logic             enough;
  rs_t              decided;

  assign limit_fixed = AVG_W'(cfg.high_rate_limit_ns) << AVG_FRAC_BITS;
  assign enough      = obs.count >= cfg.min_samples;
  assign decided     = ((average != '0) && (average < limit_fixed)) ? RS_HIGH : RS_LOW;

  always_comb begin
    cls.rate_state       = rate_state;
    cls.slow_run         = slow_run;
    cls.previous_enabled = previous_enabled;
    cls.clear            = 1'b0;
    cls.action           = ACT_NORMAL;

    if (compatible && (enabled != previous_enabled)) begin
      if (enabled) begin
        cls.rate_state = enough ? decided : RS_UNDECIDED;
        cls.slow_run   = '0;
      end else begin
        // switch off: all tracking back to reset
        cls.clear      = 1'b1;
        cls.rate_state = RS_UNDECIDED;
        cls.slow_run   = '0;
      end
      cls.previous_enabled = enabled;
    end

    if (enabled && compatible) begin
      if (cls.rate_state == RS_UNDECIDED && enough) begin
        cls.rate_state = decided;
      end
      cls.action = ACT_GENERATE;
      if (cls.rate_state == RS_HIGH) begin
        if (obs.interval >= cfg.slow_interval_ns) begin
          if (cls.slow_run != RUN_MAX) begin
            cls.slow_run = cls.slow_run + 1'b1;
          end
        end else if (obs.interval != '0) begin
          cls.slow_run = '0;
        end
        if (cls.slow_run < cfg.slow_run_limit) begin
          cls.action = ACT_PASSTHROUGH;
        end else begin
          cls.rate_state = RS_LOW;
          cls.slow_run   = '0;
        end
      end
      if (cls.action == ACT_GENERATE && cls.rate_state == RS_UNDECIDED) begin
        cls.action = ACT_MEASURING;
      end
    end
  end

endmodule

@@ sv/frame_rate_classifier.sv @@
// Frame rate classifier.
// Input stream: one transfer per present event. s_axis_tdata carries the
// 64-bit timestamp in ns, s_axis_tuser the enabled and compatible flags.
// Output stream: one transfer per event with the action, the rate class,
// the interval taken into the average (0 if none) and the average's
// integer part.
// Config channel: cfg_index/cfg_data written on cfg_valid; cfg_ready is
// always high. Write only while no event is in flight.
// The result passes through the input register, then the result register.
// Throughput: one event per cycle while the receiver accepts; the state
// update path (64-bit interval, window check, average blend, class decision)
// sets that rate.
// Reset clears all tracking state, restores register defaults and empties
// both stages. If the receiver stalls, the result register holds; one more
// event waits in the input register, after which s_axis_tready drops.
module frame_rate_classifier import frc_pkg::*; #(
  parameter int AVG_FRAC_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [TS_W-1:0]      s_axis_tdata,   // [63:0] timestamp_ns
  input  logic [1:0]           s_axis_tuser,   // [0] enabled, [1] compatible
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [1:0] action, [3:2] rate_class, [33:4] accepted_interval_ns,
  // [63:34] average_interval_ns
  output logic [63:0]          m_axis_tdata,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IV_W-1:0]      cfg_data
);

  localparam int AVG_W = IV_W + AVG_FRAC_BITS;

  cfg_t cfg;

  logic            in_valid;
  logic [TS_W-1:0] in_stamp;
  logic            in_enabled;
  logic            in_compatible;

  logic [TS_W-1:0]  last_stamp;
  logic [AVG_W-1:0] average_fixed;
  logic [CNT_W-1:0] sample_count;
  logic [RUN_W-1:0] slow_run;
  logic             previous_enabled;
  rs_t              rate_state;

  logic             advance;
  logic             observe_en;
  logic [TS_W-1:0]  last_stamp_next;
  logic [AVG_W-1:0] average_next;
  logic [AVG_W-1:0] average_out;
  obs_t             obs;
  cls_t             cls;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ns    <= 30'd4000000;
      cfg.max_interval_ns    <= 30'd100000000;
      cfg.high_rate_limit_ns <= 30'd30000000;
      cfg.slow_interval_ns   <= 30'd31500000;
      cfg.min_samples        <= 7'd8;
      cfg.slow_run_limit     <= 8'd16;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MIN_INTERVAL:   cfg.min_interval_ns    <= cfg_data;
        CFG_MAX_INTERVAL:   cfg.max_interval_ns    <= cfg_data;
        CFG_HIGH_RATE_LIM:  cfg.high_rate_limit_ns <= cfg_data;
        CFG_SLOW_INTERVAL:  cfg.slow_interval_ns   <= cfg_data;
        CFG_MIN_SAMPLES:    cfg.min_samples        <= cfg_data[CNT_W-1:0];
        CFG_SLOW_RUN_LIMIT: cfg.slow_run_limit     <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_stamp      <= s_axis_tdata;
      in_enabled    <= s_axis_tuser[0];
      in_compatible <= s_axis_tuser[1];
    end
  end

  // low class with generation on ignores timestamps entirely
  assign observe_en = in_compatible && (!in_enabled || rate_state != RS_LOW);

  frc_observe #(
    .AVG_FRAC_BITS(AVG_FRAC_BITS)
  ) u_observe (
    .now             (in_stamp),
    .observe_en      (observe_en),
    .last_stamp      (last_stamp),
    .average         (average_fixed),
    .count           (sample_count),
    .cfg             (cfg),
    .last_stamp_next (last_stamp_next),
    .average_next    (average_next),
    .obs             (obs)
  );

  frc_classify #(
    .AVG_FRAC_BITS(AVG_FRAC_BITS)
  ) u_classify (
    .enabled          (in_enabled),
    .compatible       (in_compatible),
    .previous_enabled (previous_enabled),
    .rate_state       (rate_state),
    .slow_run         (slow_run),
    .obs              (obs),
    .average          (average_next),
    .cfg              (cfg),
    .cls              (cls)
  );

  assign average_out = cls.clear ? '0 : average_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_stamp       <= '0;
      average_fixed    <= '0;
      sample_count     <= '0;
      slow_run         <= '0;
      previous_enabled <= 1'b0;
      rate_state       <= RS_UNDECIDED;
    end else if (advance) begin
      last_stamp       <= cls.clear ? '0 : last_stamp_next;
      average_fixed    <= average_out;
      sample_count     <= cls.clear ? '0 : obs.count;
      slow_run         <= cls.slow_run;
      previous_enabled <= cls.previous_enabled;
      rate_state       <= cls.rate_state;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_axis_tdata <= {average_out[AVG_W-1:AVG_FRAC_BITS], obs.interval,
                       rate_code(cls.rate_state), cls.action};
    end
  end

endmodule

@@ sv/frc_checker.sv @@
`include "frame_rate_classifier_defines.svh"

module frc_checker import frc_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 s_axis_tvalid,
  input logic                 s_axis_tready,
  input logic [TS_W-1:0]      s_axis_tdata,
  input logic [1:0]           s_axis_tuser,
  input logic                 m_axis_tvalid,
  input logic                 m_axis_tready,
  input logic [63:0]          m_axis_tdata,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [IV_W-1:0]      cfg_data
);

  `FRC_ASSERT(a_rst_empty, rst |=> (!m_axis_tvalid && s_axis_tready), "not empty after reset")

  `FRC_ASSERT_RUN(a_out_hold, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)), "stalled result changed")

  // action and class must agree
  `FRC_ASSERT_RUN(a_pass_high, (m_axis_tvalid && m_axis_tdata[1:0] == ACT_PASSTHROUGH) |-> (m_axis_tdata[3:2] == RC_HIGH), "passthrough without high class")

  `FRC_ASSERT_RUN(a_measure_undecided, (m_axis_tvalid && m_axis_tdata[1:0] == ACT_MEASURING) |-> (m_axis_tdata[3:2] == RC_UNDECIDED), "measuring with a decided class")

  `FRC_ASSERT_RUN(a_generate_low, (m_axis_tvalid && m_axis_tdata[1:0] == ACT_GENERATE) |-> (m_axis_tdata[3:2] == RC_LOW), "generate without low class")

endmodule

bind frame_rate_classifier frc_checker u_frc_checker (.*);

@@ tb/frame_rate_classifier_checker.sv @@
`timescale 1ns / 1ps

// Watches the event, result and register write channels. Each accepted event
// is run through a local model of the classifier. Each accepted result is
// compared against the oldest prediction.
module frame_rate_classifier_checker import frc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [TS_W-1:0]      s_axis_tdata,
  input  logic [1:0]           s_axis_tuser,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [63:0]          m_axis_tdata,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [IV_W-1:0]      cfg_data,
  output int                   mismatch_count,
  output int                   results_due
);

  localparam int FRAC = 8;

  typedef struct packed {
    logic [IV_W-1:0] average;
    logic [IV_W-1:0] accepted;
    logic [1:0]      rate;
    action_t         act;
  } present_result_t;

  logic [IV_W-1:0]  win_lo, win_hi, high_lim, slow_iv;
  logic [CNT_W-1:0] need_samples;
  logic [RUN_W-1:0] run_limit;

  logic [63:0]      prev_stamp;
  logic [63:0]      avg_fx;
  logic [CNT_W-1:0] samples;
  logic [RUN_W-1:0] slow_count;
  logic             was_enabled;
  logic [1:0]       rate;

  present_result_t expected_results[$];

  function automatic void clear_tracking();
    prev_stamp  = '0;
    avg_fx      = '0;
    samples     = '0;
    slow_count  = '0;
    was_enabled = 1'b0;
    rate        = RC_UNDECIDED;
  endfunction

  // Returns the interval taken into the average, 0 if none.
  function automatic logic [63:0] take_interval(input logic [63:0] now);
    logic [63:0] iv;
    iv = '0;
    if (prev_stamp != 64'd0 && now > prev_stamp) begin
      iv = now - prev_stamp;
      if (iv >= 64'(win_lo) && iv <= 64'(win_hi)) begin
        if (samples == '0) begin
          avg_fx = iv << FRAC;
        end else begin
          avg_fx = (64'd7 * avg_fx + (iv << FRAC)) >> 3;
        end
        if (samples < SAMPLE_CAP) begin
          samples = samples + 1'b1;
        end
      end else begin
        iv = '0;
      end
    end
    prev_stamp = now;
    return iv;
  endfunction

  function automatic logic [1:0] classify();
    if (samples >= need_samples && avg_fx != 64'd0 &&
        avg_fx < ({34'd0, high_lim} << FRAC)) begin
      return RC_HIGH;
    end
    return RC_LOW;
  endfunction

  function automatic present_result_t predict_present(input logic [63:0] now, input logic en,
                                                      input logic comp);
    present_result_t r;
    logic [63:0]     iv;
    action_t         act;
    iv = '0;
    if (comp && (!en || rate != RC_LOW)) begin
      iv = take_interval(now);
    end
    if (comp && en != was_enabled) begin
      if (en) begin
        rate       = (samples >= need_samples) ? classify() : RC_UNDECIDED;
        slow_count = '0;
      end else begin
        clear_tracking();
      end
      was_enabled = en;
    end
    if (!en || !comp) begin
      act = ACT_NORMAL;
    end else begin
      if (rate == RC_UNDECIDED && samples >= need_samples) begin
        rate = classify();
      end
      act = ACT_GENERATE;
      if (rate == RC_HIGH) begin
        if (iv >= 64'(slow_iv)) begin
          if (slow_count != RUN_MAX) begin
            slow_count = slow_count + 1'b1;
          end
        end else if (iv != 64'd0) begin
          slow_count = '0;
        end
        if (slow_count < run_limit) begin
          act = ACT_PASSTHROUGH;
        end else begin
          rate       = RC_LOW;
          slow_count = '0;
        end
      end
      if (act == ACT_GENERATE && rate == RC_UNDECIDED) begin
        act = ACT_MEASURING;
      end
    end
    r.act      = act;
    r.rate     = rate;
    r.accepted = iv[IV_W-1:0];
    r.average  = avg_fx[FRAC +: IV_W];
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %0s mismatch: expected %0h, got %0h", $realtime, what, want, got);
    end
  endtask

  always @(posedge clk) begin : monitor
    present_result_t want;
    present_result_t got;
    if (rst) begin
      win_lo       = 30'd4_000_000;
      win_hi       = 30'd100_000_000;
      high_lim     = 30'd30_000_000;
      slow_iv      = 30'd31_500_000;
      need_samples = 7'd8;
      run_limit    = 8'd16;
      clear_tracking();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MIN_INTERVAL:   win_lo = cfg_data;
          CFG_MAX_INTERVAL:   win_hi = cfg_data;
          CFG_HIGH_RATE_LIM:  high_lim = cfg_data;
          CFG_SLOW_INTERVAL:  slow_iv = cfg_data;
          CFG_MIN_SAMPLES:    need_samples = cfg_data[CNT_W-1:0];
          CFG_SLOW_RUN_LIMIT: run_limit = cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(predict_present(s_axis_tdata, s_axis_tuser[0],
                                                   s_axis_tuser[1]));
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", '0, m_axis_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.act != want.act) begin
            report_mismatch("action", want.act, got.act);
          end
          if (got.rate != want.rate) begin
            report_mismatch("rate_class", want.rate, got.rate);
          end
          if (got.accepted != want.accepted) begin
            report_mismatch("accepted_interval_ns", want.accepted, got.accepted);
          end
          if (got.average != want.average) begin
            report_mismatch("average_interval_ns", want.average, got.average);
          end
        end
      end
    end
    results_due = expected_results.size();
  end

endmodule

@@ tb/frame_rate_classifier_tb.sv @@
`timescale 1ns / 1ps

module frame_rate_classifier_tb;
  import frc_pkg::*;

  localparam logic [IV_W-1:0]      MAX30        = 30'h3FFF_FFFF;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;
  localparam int                   HOLD_CYCLES  = 300;
  localparam int                   LIMIT_NS     = 5_000_000;

  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [TS_W-1:0]      s_axis_tdata  = '0;   // [63:0] timestamp_ns
  logic [1:0]           s_axis_tuser  = '0;   // [0] enabled, [1] compatible
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b1;
  logic [63:0]          m_axis_tdata;        // action, rate_class, accepted, average
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index     = '0;
  logic [IV_W-1:0]      cfg_data      = '0;

  int   send_idle_pct  = 0;
  int   recv_stall_pct = 0;
  logic hold_go        = 1'b0;
  logic hold_off       = 1'b0;
  int   mismatch_count;
  int   results_due;

  frame_rate_classifier u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  frame_rate_classifier_checker u_checker (
    .clk            (clk),
    .rst            (rst),
    .s_axis_tvalid  (s_axis_tvalid),
    .s_axis_tready  (s_axis_tready),
    .s_axis_tdata   (s_axis_tdata),
    .s_axis_tuser   (s_axis_tuser),
    .m_axis_tvalid  (m_axis_tvalid),
    .m_axis_tready  (m_axis_tready),
    .m_axis_tdata   (m_axis_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .results_due    (results_due)
  );

  always #5 clk = ~clk;

  // Receiver: random stalls, plus the long hold-off below.
  initial begin
    forever begin
      @(posedge clk);
      m_axis_tready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the block fills up and stalls its input.
  initial begin
    wait (hold_go);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #(LIMIT_NS);
    $display("frame_rate_classifier regression: fail");
    $finish;
  end

  task automatic send_present(input logic [63:0] stamp, input logic en, input logic comp);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= stamp;
    s_axis_tuser  <= {comp, en};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Drain: wait until every predicted result has been seen.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [IV_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic load_config(input logic [IV_W-1:0] lo, input logic [IV_W-1:0] hi,
                             input logic [IV_W-1:0] lim, input logic [IV_W-1:0] slow,
                             input logic [IV_W-1:0] samples, input logic [IV_W-1:0] run);
    settle();
    write_reg(CFG_MIN_INTERVAL, lo);
    write_reg(CFG_MAX_INTERVAL, hi);
    write_reg(CFG_HIGH_RATE_LIM, lim);
    write_reg(CFG_SLOW_INTERVAL, slow);
    write_reg(CFG_MIN_SAMPLES, samples);
    write_reg(CFG_SLOW_RUN_LIMIT, run);
    // unused indexes go last so any aliasing onto a real register shows up
    write_reg(CFG_SPARE_LO, IV_W'($urandom));
    write_reg(CFG_SPARE_HI, IV_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [63:0] fresh_base();
    int roll;
    roll = $urandom_range(0, 3);
    if (roll == 0) return {32'd0, $urandom_range(1, 1_000_000)};
    if (roll == 1) return {$urandom, $urandom};
    if (roll == 2) return {32'hFFFF_FFFF, $urandom};   // close to wrap
    return '0;
  endfunction

  // Mostly steady frame cadence with tempo changes, plus zero stamps,
  // backward steps, out-of-window gaps, jumps and flag changes.
  task automatic random_presents(input int count);
    logic [63:0] stamp;
    logic        en;
    logic        comp;
    logic        slow_tempo;
    int          roll;
    stamp      = fresh_base();
    en         = 1'b0;
    slow_tempo = 1'b0;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        stamp = '0;
      end else if (roll < 6) begin
        stamp = stamp - 64'($urandom_range(0, 2_000_000));
      end else if (roll < 9) begin
        stamp = stamp + 64'($urandom_range(0, 4_500_000));
      end else if (roll < 11) begin
        stamp = stamp + 64'($urandom_range(100_000_001, 1_500_000_000));
      end else if (roll < 12) begin
        stamp = {$urandom, $urandom};
      end else if (roll < 14) begin
        stamp = fresh_base();
      end else if (slow_tempo) begin
        stamp = stamp + 64'($urandom_range(32_000_000, 90_000_000));
      end else begin
        stamp = stamp + 64'($urandom_range(5_000_000, 25_000_000));
      end
      if ($urandom_range(0, 99) < 4) slow_tempo = !slow_tempo;
      if ($urandom_range(0, 99) < 6) en = !en;
      comp = ($urandom_range(0, 99) >= 5);
      send_present(stamp, en, comp);
    end
  endtask

  initial begin : stimulus
    logic [63:0] stamp;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // default registers
    send_present(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0);  // not compatible
    send_present(64'd0, 1'b0, 1'b1);                    // zero stamp
    send_present(64'd10_000_000, 1'b0, 1'b1);           // no previous stamp
    send_present(64'd26_000_000, 1'b0, 1'b1);           // first sample taken whole
    send_present(64'd26_000_000, 1'b0, 1'b1);           // equal stamp
    send_present(64'd25_000_000, 1'b0, 1'b1);           // backward
    send_present(64'd25_000_001, 1'b0, 1'b1);           // below window
    stamp = 64'd325_000_001;
    send_present(stamp, 1'b0, 1'b1);                    // above window
    repeat (7) begin
      stamp = stamp + 64'd16_666_667;
      send_present(stamp, 1'b0, 1'b1);
    end
    stamp = stamp + 64'd16_666_667;
    send_present(stamp, 1'b1, 1'b1);                    // switch on, high class
    stamp = stamp + 64'd40_000_000;
    send_present(stamp, 1'b1, 1'b1);                    // slow
    stamp = stamp + 64'd3_000_000;
    send_present(stamp, 1'b1, 1'b1);                    // rejected, run kept
    stamp = stamp + 64'd40_000_000;
    send_present(stamp, 1'b1, 1'b1);
    stamp = stamp + 64'd16_000_000;
    send_present(stamp, 1'b1, 1'b1);                    // fast, run cleared
    send_present(stamp + 64'd16_000_000, 1'b1, 1'b0);   // not compatible
    stamp = stamp + 64'd32_000_000;
    send_present(stamp, 1'b0, 1'b1);                    // switch off
    stamp = stamp + 64'd16_000_000;
    send_present(stamp, 1'b1, 1'b1);                    // measuring
    stamp = stamp + 64'd16_000_000;
    send_present(stamp, 1'b1, 1'b1);
    send_present(64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1);
    send_present(64'd0, 1'b1, 1'b1);

    random_presents(150);

    for (int phase = 1; phase < 8; phase++) begin
      case (phase)
        1: load_config(30'd1_000_000, 30'd50_000_000, 30'd20_000_000, 30'd22_000_000,
                       30'd3, 30'd4);
        2: load_config('0, MAX30, MAX30, '0, '0, '0);
        // all-ones data also checks masking of the narrow registers
        3: load_config(MAX30, '0, '0, MAX30, MAX30, MAX30);
        default: load_config(IV_W'($urandom_range(0, 4_500_000)),
                             IV_W'($urandom_range(60_000_000, 120_000_000)),
                             IV_W'($urandom_range(18_000_000, 35_000_000)),
                             IV_W'($urandom_range(20_000_000, 40_000_000)),
                             IV_W'($urandom_range(0, 20)), IV_W'($urandom_range(1, 12)));
      endcase
      case (phase % 4)
        1: begin
          send_idle_pct  = 70;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 70;
        end
        3: begin
          send_idle_pct  = 35;
          recv_stall_pct = 35;
        end
        default: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
      endcase
      if (phase == 5) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_go        = 1'b1;
      end
      random_presents(170);
    end

    settle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && results_due == 0) begin
      $display("frame_rate_classifier regression: pass");
    end else begin
      $display("frame_rate_classifier regression: fail");
    end
    $finish;
  end

endmodule
